// ----- rtl/hfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_pkg
// Shared types, codes and constants of the header field parser.
// ----------------------------------------------------------------------------
package hfp_pkg;

    // Default length limits
    localparam int NAME_MAX_DEF  = 256;
    localparam int VALUE_MAX_DEF = 8192;

    // Field limit register
    localparam int             LIMIT_W   = 10;
    localparam logic [9:0]     LIMIT_RST = 10'd100;
    localparam logic [9:0]     COUNT_SAT = 10'd1023;

    // Trim count field
    localparam int             TRIM_W   = 14;
    localparam int             TRIM_MAX = 16383;

    // Result queue depth
    localparam int RES_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    typedef enum logic [2:0] {
        KIND_NAME  = 3'd0,
        KIND_VALUE = 3'd1,
        KIND_DROP  = 3'd2,
        KIND_FIELD = 3'd3,
        KIND_END   = 3'd4,
        KIND_ERROR = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ERR_FIELDS = 2'd0,
        ERR_NAME   = 2'd1,
        ERR_VALUE  = 2'd2,
        ERR_FOLDED = 2'd3
    } t_err;

    // One result item
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic               ebs;
        logic [TRIM_W-1:0]  trim;
        t_err               err;
        logic               last;
    } t_res;

    // Results of one accepted byte, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_push;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

    function automatic t_res mk_res(input t_kind kind, input logic [7:0] data,
                                    input logic ebs, input logic [TRIM_W-1:0] trim,
                                    input t_err err);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.ebs  = ebs;
        r.trim = trim;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/header_field_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_field_parser
// Streams a message header byte by byte into name, value and control results.
// ----------------------------------------------------------------------------
// Output: a result is registered in the result queue before it is on m_axis.
// Throughput: one byte per cycle while each byte causes at most one result and
//   m_axis_tready is high; a byte causing two results gives them out in order,
//   and the input stalls when the four-entry result queue has fewer than two free entries.
// Reset (synchronous, active low): parser at line start with all counts zero,
//   result queue empty, field limit 100.
module header_field_parser #(
    parameter int NAME_MAX  = hfp_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = hfp_pkg::VALUE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] ended_by_stream_end,
                                        // [22:9] trim_count, [24:23] error_code
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,   // last
    // Field limit write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);

    logic [hfp_pkg::LIMIT_W-1:0] r_field_limit;
    hfp_pkg::t_push              push;
    hfp_pkg::t_res               res;
    logic                        room;
    logic                        accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    // Hold the field limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_limit <= hfp_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_field_limit <= i_cfg_data;
        end
    end

    hfp_core #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_byte        (s_axis_tdata),
        .i_eos         (s_axis_tlast),
        .i_field_limit (r_field_limit),
        .o_push        (push)
    );

    hfp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    // Pack the result onto the output request
    assign m_axis_tdata = {7'd0, res.err, res.trim, res.ebs, res.data};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

// ----- rtl/hfp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_core
// Parser state and per-byte step logic; emits up to two results per byte.
// ----------------------------------------------------------------------------
module hfp_core #(
    parameter int NAME_MAX  = hfp_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = hfp_pkg::VALUE_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [7:0]                  i_byte,
    input  logic                        i_eos,
    input  logic [hfp_pkg::LIMIT_W-1:0] i_field_limit,
    output hfp_pkg::t_push              o_push
);

    localparam int NW = $clog2(NAME_MAX + 1);
    localparam int VW = $clog2(VALUE_MAX + 1);

    typedef enum logic [2:0] {
        PH_LINE  = 3'd0,
        PH_NAME  = 3'd1,
        PH_SKIP  = 3'd2,
        PH_VALUE = 3'd3,
        PH_CR    = 3'd4,
        PH_EOL   = 3'd5
    } t_phase;

    t_phase                      r_phase,     n_phase;
    logic [NW-1:0]               r_name_len,  n_name_len;
    logic [VW-1:0]               r_value_len, n_value_len;
    logic                        r_seen,      n_seen;
    logic [VW-1:0]               r_trail,     n_trail;
    logic                        r_folded,    n_folded;
    logic [hfp_pkg::LIMIT_W-1:0] r_count,     n_count;

    logic [hfp_pkg::TRIM_W-1:0]  trim_sat;
    hfp_pkg::t_res               res0, res1, ls_res;
    logic [1:0]                  cnt;
    logic                        restart, fin_end, do_vb, do_ls, vb_fold, ls_has;
    logic [hfp_pkg::LIMIT_W-1:0] ls_count;

    // Saturate the trailing run to the trim field
    always_comb begin
        if (32'(r_trail) > 32'(hfp_pkg::TRIM_MAX)) begin
            trim_sat = hfp_pkg::TRIM_W'(hfp_pkg::TRIM_MAX);
        end else begin
            trim_sat = hfp_pkg::TRIM_W'(r_trail);
        end
    end

    // Step one byte
    always_comb begin
        n_phase     = r_phase;
        n_name_len  = r_name_len;
        n_value_len = r_value_len;
        n_seen      = r_seen;
        n_trail     = r_trail;
        n_folded    = r_folded;
        n_count     = r_count;
        res0        = '0;
        res1        = '0;
        ls_res      = '0;
        ls_has      = 1'b0;
        cnt         = 2'd0;
        restart     = 1'b0;
        fin_end     = 1'b0;
        do_vb       = 1'b0;
        do_ls       = 1'b0;
        vb_fold     = r_folded;
        ls_count    = r_count;

        unique case (r_phase)
            PH_NAME: begin
                if (i_eos) begin
                    res0    = hfp_pkg::mk_res(hfp_pkg::KIND_ERROR, 8'd0, 1'b0, '0,
                                              hfp_pkg::ERR_NAME);
                    cnt     = 2'd1;
                    restart = 1'b1;
                end else if (i_byte == hfp_pkg::CH_COLON) begin
                    n_phase = PH_SKIP;
                end else if (i_byte == hfp_pkg::CH_LF) begin
                    res0        = hfp_pkg::mk_res(hfp_pkg::KIND_DROP, 8'd0, 1'b0, '0,
                                                  hfp_pkg::ERR_FIELDS);
                    cnt         = 2'd1;
                    n_name_len  = '0;
                    n_value_len = '0;
                    n_seen      = 1'b0;
                    n_trail     = '0;
                    n_folded    = 1'b0;
                    n_phase     = PH_LINE;
                end else if (r_name_len >= NW'(NAME_MAX)) begin
                    res0    = hfp_pkg::mk_res(hfp_pkg::KIND_ERROR, 8'd0, 1'b0, '0,
                                              hfp_pkg::ERR_NAME);
                    cnt     = 2'd1;
                    restart = 1'b1;
                end else begin
                    res0       = hfp_pkg::mk_res(hfp_pkg::KIND_NAME, i_byte, 1'b0, '0,
                                                 hfp_pkg::ERR_FIELDS);
                    cnt        = 2'd1;
                    n_name_len = r_name_len + NW'(1);
                end
            end
            PH_SKIP: begin
                if (i_eos) begin
                    fin_end = 1'b1;
                end else if (!hfp_pkg::is_ws(i_byte)) begin
                    do_vb = 1'b1;
                end
            end
            PH_VALUE: begin
                if (i_eos) begin
                    fin_end = 1'b1;
                end else begin
                    do_vb = 1'b1;
                end
            end
            PH_CR: begin
                if (i_eos) begin
                    fin_end = 1'b1;
                end else if (i_byte == hfp_pkg::CH_LF) begin
                    n_phase = PH_EOL;
                end else begin
                    res0    = hfp_pkg::mk_res(hfp_pkg::KIND_ERROR, 8'd0, 1'b0, '0,
                                              r_folded ? hfp_pkg::ERR_FOLDED
                                                       : hfp_pkg::ERR_VALUE);
                    cnt     = 2'd1;
                    restart = 1'b1;
                end
            end
            PH_EOL: begin
                if (i_eos) begin
                    fin_end = 1'b1;
                end else if (i_byte == hfp_pkg::CH_SP || i_byte == hfp_pkg::CH_TAB) begin
                    // Folded continuation line
                    n_folded = 1'b1;
                    vb_fold  = 1'b1;
                    do_vb    = 1'b1;
                end else begin
                    res0     = hfp_pkg::mk_res(hfp_pkg::KIND_FIELD, 8'd0, 1'b0, trim_sat,
                                               hfp_pkg::ERR_FIELDS);
                    cnt      = 2'd1;
                    ls_count = (r_count < hfp_pkg::COUNT_SAT) ? r_count + 10'd1 : r_count;
                    do_ls    = 1'b1;
                end
            end
            default: begin
                if (i_eos) begin
                    res0    = hfp_pkg::mk_res(hfp_pkg::KIND_END, 8'd0, 1'b1, '0,
                                              hfp_pkg::ERR_FIELDS);
                    cnt     = 2'd1;
                    restart = 1'b1;
                end else begin
                    do_ls = 1'b1;
                end
            end
        endcase

        // Field complete, then header end by stream end
        if (fin_end) begin
            res0    = hfp_pkg::mk_res(hfp_pkg::KIND_FIELD, 8'd0, 1'b0, trim_sat,
                                      hfp_pkg::ERR_FIELDS);
            res1    = hfp_pkg::mk_res(hfp_pkg::KIND_END, 8'd0, 1'b1, '0,
                                      hfp_pkg::ERR_FIELDS);
            cnt     = 2'd2;
            restart = 1'b1;
        end

        // Value byte
        if (do_vb) begin
            if (i_byte == hfp_pkg::CH_CR) begin
                n_phase = PH_CR;
            end else if (i_byte == hfp_pkg::CH_LF) begin
                n_phase = PH_EOL;
            end else if (r_value_len >= VW'(VALUE_MAX)) begin
                res0    = hfp_pkg::mk_res(hfp_pkg::KIND_ERROR, 8'd0, 1'b0, '0,
                                          vb_fold ? hfp_pkg::ERR_FOLDED
                                                  : hfp_pkg::ERR_VALUE);
                cnt     = 2'd1;
                restart = 1'b1;
            end else begin
                n_value_len = r_value_len + VW'(1);
                n_phase     = PH_VALUE;
                if (hfp_pkg::is_ws(i_byte)) begin
                    // Suppress leading whitespace, count trailing whitespace
                    if (r_seen) begin
                        res0    = hfp_pkg::mk_res(hfp_pkg::KIND_VALUE, i_byte, 1'b0, '0,
                                                  hfp_pkg::ERR_FIELDS);
                        cnt     = 2'd1;
                        n_trail = r_trail + VW'(1);
                    end
                end else begin
                    n_seen  = 1'b1;
                    n_trail = '0;
                    res0    = hfp_pkg::mk_res(hfp_pkg::KIND_VALUE, i_byte, 1'b0, '0,
                                              hfp_pkg::ERR_FIELDS);
                    cnt     = 2'd1;
                end
            end
        end

        // First byte of a line
        if (do_ls) begin
            if (i_byte == hfp_pkg::CH_CR || i_byte == hfp_pkg::CH_LF) begin
                ls_res  = hfp_pkg::mk_res(hfp_pkg::KIND_END, i_byte, 1'b0, '0,
                                          hfp_pkg::ERR_FIELDS);
                ls_has  = 1'b1;
                restart = 1'b1;
            end else if (i_field_limit != '0 && ls_count == i_field_limit) begin
                ls_res  = hfp_pkg::mk_res(hfp_pkg::KIND_ERROR, 8'd0, 1'b0, '0,
                                          hfp_pkg::ERR_FIELDS);
                ls_has  = 1'b1;
                restart = 1'b1;
            end else begin
                n_count     = ls_count;
                n_value_len = '0;
                n_seen      = 1'b0;
                n_trail     = '0;
                n_folded    = 1'b0;
                if (i_byte == hfp_pkg::CH_COLON) begin
                    n_name_len = '0;
                    n_phase    = PH_SKIP;
                end else begin
                    ls_res     = hfp_pkg::mk_res(hfp_pkg::KIND_NAME, i_byte, 1'b0, '0,
                                                 hfp_pkg::ERR_FIELDS);
                    ls_has     = 1'b1;
                    n_name_len = NW'(1);
                    n_phase    = PH_NAME;
                end
            end
            if (ls_has) begin
                if (cnt == 2'd0) begin
                    res0 = ls_res;
                end else begin
                    res1 = ls_res;
                end
                cnt = cnt + 2'd1;
            end
        end

        // Restart after header end or error
        if (restart) begin
            n_phase     = PH_LINE;
            n_name_len  = '0;
            n_value_len = '0;
            n_seen      = 1'b0;
            n_trail     = '0;
            n_folded    = 1'b0;
            n_count     = '0;
        end

        // Mark the final result of this byte
        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end

        o_push.cnt = i_valid ? cnt : 2'd0;
        o_push.r0  = res0;
        o_push.r1  = res1;
    end

    // Hold parser state, advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE;
            r_name_len  <= '0;
            r_value_len <= '0;
            r_seen      <= 1'b0;
            r_trail     <= '0;
            r_folded    <= 1'b0;
            r_count     <= '0;
        end else if (i_valid) begin
            r_phase     <= n_phase;
            r_name_len  <= n_name_len;
            r_value_len <= n_value_len;
            r_seen      <= n_seen;
            r_trail     <= n_trail;
            r_folded    <= n_folded;
            r_count     <= n_count;
        end
    end

endmodule

// ----- rtl/hfp_res_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_res_fifo
// Small result queue: takes up to two results per cycle, gives one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module hfp_res_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hfp_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output hfp_pkg::t_res  o_res
);

    localparam int DEPTH = hfp_pkg::RES_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    hfp_pkg::t_res r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    // Room for the two results a byte may cause
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    // Advance pointers and fill count
    always_comb begin
        n_wr    = r_wr + PW'(i_push.cnt);
        n_rd    = pop ? r_rd + PW'(1) : r_rd;
        n_count = r_count + CW'(i_push.cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store results; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.r1;
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for header_field_parser. A queue of header bytes feeds
// the input stream, and every accepted request runs through a local model of
// the parser whose results are queued and compared, field by field, against
// the result stream. Directed cases come first, then random headers under
// several field limits and idle patterns, then a long name that reaches the
// name limit.
// ----------------------------------------------------------------------------
module testbench;
    import hfp_pkg::*;

    localparam int NAME_LEN_MAX  = NAME_MAX_DEF;
    localparam int VALUE_LEN_MAX = VALUE_MAX_DEF;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 40;
    localparam int SEG_COUNT     = 9;
    localparam int SEG_BYTES     = 110;

    typedef enum logic [2:0] {
        ST_LINE_START = 3'd0,
        ST_NAME       = 3'd1,
        ST_SKIP_WS    = 3'd2,
        ST_VALUE      = 3'd3,
        ST_GOT_CR     = 3'd4,
        ST_LINE_END   = 3'd5
    } t_parse_state;

    // One byte request of the header stream
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_hdr_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] out_byte, [8] ended_by_stream_end,
                                         // [22:9] trim_count, [24:23] error_code
    logic [2:0]  m_axis_tuser;           // [2:0] kind
    logic        m_axis_tlast;           // last
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_data    = 10'd0;

    // Parser model state
    t_parse_state ps_state;
    logic [8:0]   ps_name_len;
    logic [13:0]  ps_value_len;
    logic [13:0]  ps_trail_ws;
    logic         ps_seen_text;
    logic         ps_folded;
    logic [9:0]   ps_field_cnt;
    logic [9:0]   ps_limit;

    t_res        step_out[$];
    t_res        parse_results[$];
    t_hdr_item   header_bytes[$];
    t_hdr_item   next_item;
    t_res        want_res;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned bytes_queued  = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned cycle_cnt     = 0;

    header_field_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] b);
        return b inside {CH_SP, CH_TAB, CH_VT, CH_FF};
    endfunction

    function automatic void add_result(input t_kind k, input logic [7:0] d,
                                       input logic ebs, input logic [13:0] trim,
                                       input t_err code);
        t_res r;
        r      = '0;
        r.kind = k;
        r.data = d;
        r.ebs  = ebs;
        r.trim = trim;
        r.err  = code;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void clear_field();
        ps_name_len  = '0;
        ps_value_len = '0;
        ps_seen_text = 1'b0;
        ps_trail_ws  = '0;
        ps_folded    = 1'b0;
    endfunction

    function automatic void restart_header();
        clear_field();
        ps_field_cnt = '0;
        ps_state     = ST_LINE_START;
    endfunction

    function automatic void raise_error(input t_err code);
        add_result(KIND_ERROR, 8'h00, 1'b0, 14'd0, code);
        restart_header();
    endfunction

    function automatic void end_on_stream();
        add_result(KIND_END, 8'h00, 1'b1, 14'd0, ERR_FIELDS);
        restart_header();
    endfunction

    function automatic void close_field();
        add_result(KIND_FIELD, 8'h00, 1'b0, ps_trail_ws, ERR_FIELDS);
        if (ps_field_cnt != COUNT_SAT) begin
            ps_field_cnt = ps_field_cnt + 1'b1;
        end
        clear_field();
        ps_state = ST_LINE_START;
    endfunction

    function automatic void take_name(input logic [7:0] b);
        if (b == CH_COLON) begin
            ps_state = ST_SKIP_WS;
        end else if (b == CH_LF) begin
            add_result(KIND_DROP, 8'h00, 1'b0, 14'd0, ERR_FIELDS);
            clear_field();
            ps_state = ST_LINE_START;
        end else if (ps_name_len >= NAME_LEN_MAX) begin
            raise_error(ERR_NAME);
        end else begin
            add_result(KIND_NAME, b, 1'b0, 14'd0, ERR_FIELDS);
            ps_name_len = ps_name_len + 1'b1;
            ps_state    = ST_NAME;
        end
    endfunction

    function automatic void take_value(input logic [7:0] b);
        if (b == CH_CR) begin
            ps_state = ST_GOT_CR;
        end else if (b == CH_LF) begin
            ps_state = ST_LINE_END;
        end else if (ps_value_len >= VALUE_LEN_MAX) begin
            if (ps_folded) begin
                raise_error(ERR_FOLDED);
            end else begin
                raise_error(ERR_VALUE);
            end
        end else begin
            ps_value_len = ps_value_len + 1'b1;
            ps_state     = ST_VALUE;
            // Leading blanks are counted but never emitted
            if (!is_blank(b)) begin
                ps_seen_text = 1'b1;
                ps_trail_ws  = '0;
                add_result(KIND_VALUE, b, 1'b0, 14'd0, ERR_FIELDS);
            end else if (ps_seen_text) begin
                add_result(KIND_VALUE, b, 1'b0, 14'd0, ERR_FIELDS);
                ps_trail_ws = ps_trail_ws + 1'b1;
            end
        end
    endfunction

    function automatic void take_line_start(input logic [7:0] b);
        if (b == CH_CR || b == CH_LF) begin
            add_result(KIND_END, b, 1'b0, 14'd0, ERR_FIELDS);
            restart_header();
        end else if (ps_limit != 0 && ps_field_cnt == ps_limit) begin
            raise_error(ERR_FIELDS);
        end else begin
            clear_field();
            take_name(b);
        end
    endfunction

    // Run one accepted byte through the model and queue its results
    function automatic void parse_byte(input logic [7:0] b, input logic eos);
        t_res r;
        step_out.delete();
        case (ps_state)
            ST_NAME: begin
                if (eos) raise_error(ERR_NAME);
                else take_name(b);
            end
            ST_SKIP_WS: begin
                if (eos) begin
                    close_field();
                    end_on_stream();
                end else if (!is_blank(b)) begin
                    take_value(b);
                end
            end
            ST_VALUE: begin
                if (eos) begin
                    close_field();
                    end_on_stream();
                end else begin
                    take_value(b);
                end
            end
            ST_GOT_CR: begin
                if (eos) begin
                    close_field();
                    end_on_stream();
                end else if (b == CH_LF) begin
                    ps_state = ST_LINE_END;
                end else if (ps_folded) begin
                    raise_error(ERR_FOLDED);
                end else begin
                    raise_error(ERR_VALUE);
                end
            end
            ST_LINE_END: begin
                if (eos) begin
                    close_field();
                    end_on_stream();
                end else if (b == CH_SP || b == CH_TAB) begin
                    ps_folded = 1'b1;
                    take_value(b);
                end else begin
                    close_field();
                    take_line_start(b);
                end
            end
            default: begin
                if (eos) end_on_stream();
                else take_line_start(b);
            end
        endcase
        if (step_out.size() > 0) begin
            r      = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i]) parse_results.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b);
        t_hdr_item it;
        it.data = b;
        it.eos  = 1'b0;
        header_bytes.push_back(it);
        bytes_queued++;
    endfunction

    // End of stream; the data byte is ignored, so make it random
    function automatic void put_eos();
        t_hdr_item it;
        it.data = 8'($urandom);
        it.eos  = 1'b1;
        header_bytes.push_back(it);
        bytes_queued++;
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic logic [7:0] rand_token();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        if (c == CH_COLON) c = 8'h2D;
        return c;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(3))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // Value text and its line end; a few lines break or hit end of stream
    function automatic void queue_value_line();
        int r;
        repeat ($urandom_range(0, 12)) begin
            r = $urandom_range(99);
            if (r < 60) put_byte(8'($urandom_range(33, 126)));
            else if (r < 90) put_byte(rand_blank());
            else put_byte(8'($urandom));
        end
        r = $urandom_range(99);
        if (r < 50) begin
            put_byte(CH_CR);
            put_byte(CH_LF);
        end else if (r < 88) begin
            put_byte(CH_LF);
        end else if (r < 93) begin
            put_byte(CH_CR);
            put_byte(rand_token());
        end else begin
            put_eos();
        end
    endfunction

    function automatic void queue_field();
        int r;
        int n;
        r = $urandom_range(99);
        n = $urandom_range(1, 10);
        if (r < 8) begin
            // Line without a colon, dropped at its LF
            repeat (n) put_byte(rand_token());
            if ($urandom_range(1)) put_byte(CH_CR);
            put_byte(CH_LF);
        end else if (r < 12) begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
        end else begin
            repeat (n) put_byte(rand_token());
            if ($urandom_range(49) == 0) put_byte(CH_CR);
            put_byte(CH_COLON);
            repeat ($urandom_range(0, 3)) put_byte(rand_blank());
            queue_value_line();
            // Folded continuation lines
            while ($urandom_range(99) < 15) begin
                put_byte($urandom_range(1) ? CH_SP : CH_TAB);
                queue_value_line();
            end
        end
    endfunction

    function automatic void queue_header();
        int r;
        repeat ($urandom_range(0, 6)) queue_field();
        r = $urandom_range(99);
        if (r < 40) begin
            put_byte(CH_CR);
            put_byte(CH_LF);
        end else if (r < 65) begin
            put_byte(CH_LF);
        end else if (r < 75) begin
            put_byte(CH_CR);
        end else if (r < 95) begin
            put_eos();
        end
    endfunction

    function automatic logic [9:0] segment_limit(input int seg);
        case (seg)
            0: return 10'd1;
            1: return 10'd0;
            2: return 10'd3;
            3: return 10'd1023;
            4: return 10'd2;
            5: return 10'($urandom_range(1023));
            6: return 10'd1;
            7: return 10'd5;
            default: return 10'd0;
        endcase
    endfunction

    // Wait until every request is taken and every result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (header_bytes.size() != 0 || s_axis_tvalid || parse_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [9:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ps_limit = value;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned start;
        ps_limit = LIMIT_RST;
        restart_header();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: line-start terminators, CR in a name, skipped and trimmed
        // blanks, folding, end of stream after a colon and inside a name,
        // CR not followed by LF
        @(negedge i_clk);
        send_idle_pct = 24;
        recv_idle_pct = 81;
        put_eos();
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_text("a");
        put_byte(CH_CR);
        put_byte(CH_COLON);
        put_byte(CH_TAB);
        put_byte(CH_VT);
        put_text("x ");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(CH_TAB);
        put_text("y");
        put_byte(CH_FF);
        put_byte(CH_LF);
        put_text("z");
        put_byte(CH_LF);
        put_byte(8'hFF);
        put_byte(CH_COLON);
        put_eos();
        put_byte(8'h00);
        put_eos();
        put_text("k:v");
        put_byte(CH_CR);
        put_text("q");
        wait_idle();

        // Random headers under several limits and idle patterns
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            write_limit(segment_limit(seg));
            @(negedge i_clk);
            if (seg == 3) begin
                send_idle_pct = 81;
                recv_idle_pct = 24;
            end else if (seg == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            start = bytes_queued;
            while (bytes_queued - start < SEG_BYTES) queue_header();
            wait_idle();
        end

        // Long name: one byte past the name limit
        @(negedge i_clk);
        put_eos();
        repeat (NAME_LEN_MAX + 1) put_text("n");
        put_eos();
        wait_idle();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: predict on acceptance, then advance or hold
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            parse_byte(s_axis_tdata, s_axis_tlast);
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (header_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = header_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.data;
                s_axis_tlast  <= next_item.eos;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result stall pattern
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (parse_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX) begin
                    $error("result with none expected: kind %0d, data %0h",
                           m_axis_tuser, m_axis_tdata);
                end
            end else begin
                want_res = parse_results.pop_front();
                check_field("kind", 32'(want_res.kind), 32'(m_axis_tuser));
                check_field("out_byte", 32'(want_res.data), 32'(m_axis_tdata[7:0]));
                check_field("ended_by_stream_end", 32'(want_res.ebs), 32'(m_axis_tdata[8]));
                check_field("trim_count", 32'(want_res.trim), 32'(m_axis_tdata[22:9]));
                check_field("error_code", 32'(want_res.err), 32'(m_axis_tdata[24:23]));
                check_field("last", 32'(want_res.last), 32'(m_axis_tlast));
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
rtl/hfp_pkg.sv
rtl/hfp_core.sv
rtl/hfp_res_fifo.sv
rtl/header_field_parser.sv
verif/testbench.sv
